>>> design/prf_pkg.sv
// Package for the packet frame receiver: frame byte codes, status codes,
// controller state type and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package prf_pkg;

  localparam logic [7:0] HEAD_BYTE = 8'hCC;
  localparam logic [7:0] TAIL_BYTE = 8'hB9;
  localparam logic [7:0] END1_BYTE = 8'h0D;
  localparam logic [7:0] END2_BYTE = 8'h0A;

  localparam int unsigned LEN_W   = 7;
  localparam int unsigned STAT_W  = 3;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 7'd64;

  typedef enum logic [STAT_W-1:0] {
    STAT_GOOD     = 3'd0,
    STAT_BAD_LEN  = 3'd1,
    STAT_BAD_TAIL = 3'd2,
    STAT_BAD_CSUM = 3'd3,
    STAT_BAD_END1 = 3'd4,
    STAT_BAD_END2 = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_HEAD,
    ST_LEN,
    ST_ID,
    ST_PAY,
    ST_TAIL,
    ST_CSUM,
    ST_END1,
    ST_END2,
    ST_RD,
    ST_LOAD
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    clear;       // new frame: zero count, checksum, length
    logic    len_load;    // capture length byte
    logic    store;       // write byte to store, bump count
    logic    csum_init;   // checksum restarts at this byte (ID)
    logic    err_load;    // load an error item into the output register
    logic    err_use_byte;// error frame_length comes from the input byte
    status_e err_code;
    logic    rd_clear;    // start emission at store index 0
    logic    rd_next;     // advance emission index
    logic    data_load;   // load a stored byte into the output register
  } prf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_head;
    logic is_tail;
    logic is_end1;
    logic is_end2;
    logic len_ok;
    logic csum_ok;
    logic more_pay;   // declared length above one
    logic pay_done;   // this payload byte completes the frame
    logic rd_last;    // emission index is the final stored byte
    logic out_free;   // output register can take an item this cycle
  } prf_stat_t;

  function automatic logic [7:0] bsd_add(input logic [7:0] sum, input logic [7:0] b);
    logic [7:0] rot;
    rot = {sum[0], sum[7:1]};
    return rot + b;
  endfunction

endpackage

>>> design/prf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module prf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/prf_ctrl.sv
// Frame parser controller: state machine over the frame layout and the
// emission of a good frame. Uses prf_pkg types.
`timescale 1ns / 1ps

module prf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prf_pkg::prf_stat_t  stat_i,
  output prf_pkg::prf_cmd_t   cmd_o
);

  prf_pkg::state_e state_q, state_d;
  logic            in_acc;

  // byte states take input only when an error item could be placed
  always_comb begin
    unique case (state_q)
      prf_pkg::ST_RD, prf_pkg::ST_LOAD: in_ready_o = 1'b0;
      default:                          in_ready_o = stat_i.out_free;
    endcase
  end

  assign in_acc = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prf_pkg::ST_HEAD: if (in_acc && stat_i.is_head) state_d = prf_pkg::ST_LEN;
      prf_pkg::ST_LEN: if (in_acc) begin
        state_d = stat_i.len_ok ? prf_pkg::ST_ID : prf_pkg::ST_HEAD;
      end
      prf_pkg::ST_ID: if (in_acc) begin
        state_d = stat_i.more_pay ? prf_pkg::ST_PAY : prf_pkg::ST_TAIL;
      end
      prf_pkg::ST_PAY: if (in_acc && stat_i.pay_done) state_d = prf_pkg::ST_TAIL;
      prf_pkg::ST_TAIL: if (in_acc) begin
        state_d = stat_i.is_tail ? prf_pkg::ST_CSUM : prf_pkg::ST_HEAD;
      end
      prf_pkg::ST_CSUM: if (in_acc) begin
        state_d = stat_i.csum_ok ? prf_pkg::ST_END1 : prf_pkg::ST_HEAD;
      end
      prf_pkg::ST_END1: if (in_acc) begin
        state_d = stat_i.is_end1 ? prf_pkg::ST_END2 : prf_pkg::ST_HEAD;
      end
      prf_pkg::ST_END2: if (in_acc) begin
        state_d = stat_i.is_end2 ? prf_pkg::ST_RD : prf_pkg::ST_HEAD;
      end
      prf_pkg::ST_RD: state_d = prf_pkg::ST_LOAD;
      prf_pkg::ST_LOAD: if (stat_i.out_free) begin
        state_d = stat_i.rd_last ? prf_pkg::ST_HEAD : prf_pkg::ST_RD;
      end
      default: state_d = prf_pkg::ST_HEAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.err_code = prf_pkg::STAT_GOOD;
    unique case (state_q)
      prf_pkg::ST_HEAD: cmd_o.clear = in_acc & stat_i.is_head;
      prf_pkg::ST_LEN: begin
        cmd_o.len_load     = in_acc & stat_i.len_ok;
        cmd_o.err_load     = in_acc & ~stat_i.len_ok;
        cmd_o.err_use_byte = 1'b1;
        cmd_o.err_code     = prf_pkg::STAT_BAD_LEN;
      end
      prf_pkg::ST_ID: begin
        cmd_o.store     = in_acc;
        cmd_o.csum_init = 1'b1;
      end
      prf_pkg::ST_PAY: cmd_o.store = in_acc;
      prf_pkg::ST_TAIL: begin
        cmd_o.err_load = in_acc & ~stat_i.is_tail;
        cmd_o.err_code = prf_pkg::STAT_BAD_TAIL;
      end
      prf_pkg::ST_CSUM: begin
        cmd_o.err_load = in_acc & ~stat_i.csum_ok;
        cmd_o.err_code = prf_pkg::STAT_BAD_CSUM;
      end
      prf_pkg::ST_END1: begin
        cmd_o.err_load = in_acc & ~stat_i.is_end1;
        cmd_o.err_code = prf_pkg::STAT_BAD_END1;
      end
      prf_pkg::ST_END2: begin
        cmd_o.err_load = in_acc & ~stat_i.is_end2;
        cmd_o.err_code = prf_pkg::STAT_BAD_END2;
        cmd_o.rd_clear = in_acc & stat_i.is_end2;
      end
      prf_pkg::ST_RD: ;
      prf_pkg::ST_LOAD: begin
        cmd_o.data_load = stat_i.out_free;
        cmd_o.rd_next   = stat_i.out_free & ~stat_i.rd_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prf_pkg::ST_HEAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/prf_dpath.sv
// Frame parser datapath: length limit register, counters, BSD checksum,
// byte store (prf_ram) and the output register. Uses prf_pkg and prf_ram.
`timescale 1ns / 1ps

module prf_dpath #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prf_pkg::LEN_W-1:0]      cfg_data_i,
  input  logic [7:0]                     in_byte_i,
  input  prf_pkg::prf_cmd_t              cmd_i,
  output prf_pkg::prf_stat_t             stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic [prf_pkg::STAT_W-1:0]     out_status_o,
  output logic [prf_pkg::LEN_W-1:0]      out_len_o,
  output logic                           out_last_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0]  MAX_PAY_B = 8'(MAX_PAYLOAD);

  logic [prf_pkg::LEN_W-1:0] max_len_q;
  logic [prf_pkg::LEN_W-1:0] count_q, count_d;
  logic [prf_pkg::LEN_W-1:0] decl_q, decl_d;
  logic [7:0]                csum_q, csum_d;
  logic [prf_pkg::LEN_W-1:0] rd_idx_q, rd_idx_d;
  logic [prf_pkg::LEN_W-1:0] last_idx;
  logic [7:0]                count_inc;
  logic [7:0]                expect_csum;
  logic                      ram_we;
  logic [7:0]                ram_rdata;

  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_byte_q, out_byte_d;
  logic [prf_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [prf_pkg::LEN_W-1:0]  out_len_q, out_len_d;
  logic                       out_last_q, out_last_d;

  assign count_inc   = {1'b0, count_q} + 8'd1;
  assign expect_csum = (decl_q == '0) ? 8'd0 : csum_q;
  // zero length still emits the ID byte
  assign last_idx    = (decl_q == '0) ? '0 : decl_q - 7'd1;

  always_comb begin
    stat_o.is_head  = in_byte_i == prf_pkg::HEAD_BYTE;
    stat_o.is_tail  = in_byte_i == prf_pkg::TAIL_BYTE;
    stat_o.is_end1  = in_byte_i == prf_pkg::END1_BYTE;
    stat_o.is_end2  = in_byte_i == prf_pkg::END2_BYTE;
    stat_o.len_ok   = (in_byte_i <= {1'b0, max_len_q}) && (in_byte_i <= MAX_PAY_B);
    stat_o.csum_ok  = in_byte_i == expect_csum;
    stat_o.more_pay = decl_q > 7'd1;
    stat_o.pay_done = count_inc >= {1'b0, decl_q};
    stat_o.rd_last  = rd_idx_q == last_idx;
    stat_o.out_free = ~out_valid_q | out_ready_i;
  end

  always_comb begin
    count_d  = count_q;
    decl_d   = decl_q;
    csum_d   = csum_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.clear) begin
      count_d = '0;
      decl_d  = '0;
      csum_d  = '0;
    end
    if (cmd_i.len_load) decl_d = in_byte_i[prf_pkg::LEN_W-1:0];
    if (cmd_i.store) begin
      count_d = count_inc[prf_pkg::LEN_W-1:0];
      csum_d  = prf_pkg::bsd_add(cmd_i.csum_init ? 8'd0 : csum_q, in_byte_i);
    end
    if (cmd_i.rd_clear) rd_idx_d = '0;
    if (cmd_i.rd_next)  rd_idx_d = rd_idx_q + 7'd1;
  end

  assign ram_we = cmd_i.store && ({1'b0, count_q} < MAX_PAY_B);

  prf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(count_q)),
    .wdata_i (in_byte_i),
    .raddr_i (AW'(rd_idx_q)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    if (cmd_i.err_load) begin
      out_valid_d  = 1'b1;
      out_byte_d   = '0;
      out_status_d = cmd_i.err_code;
      out_len_d    = cmd_i.err_use_byte ? in_byte_i[prf_pkg::LEN_W-1:0] : decl_q;
      out_last_d   = 1'b1;
    end else if (cmd_i.data_load) begin
      out_valid_d  = 1'b1;
      out_byte_d   = ram_rdata;
      out_status_d = prf_pkg::STAT_GOOD;
      out_len_d    = decl_q;
      out_last_d   = stat_o.rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= prf_pkg::MAX_LENGTH_RST;
      count_q     <= '0;
      decl_q      <= '0;
      csum_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_data_i;
      count_q     <= count_d;
      decl_q      <= decl_d;
      csum_q      <= csum_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_status_o = out_status_q;
  assign out_len_o    = out_len_q;
  assign out_last_o   = out_last_q;

endmodule

>>> design/packet_frame_receiver_unit.sv
// Packet frame receiver top level: parses CC/len/ID/payload/B9/csum/0D/0A
// frames. Depends on prf_pkg, prf_ctrl, prf_dpath (which holds prf_ram).
`timescale 1ns / 1ps
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid/tready      | tdata[7:0] data_byte
//  m_axis   | out | m_axis_tvalid/tready      | tdata[7:0] out_byte,
//           |     |                           | tdata[14:8] frame_length,
//           |     |                           | tuser[2:0] status, tlast = last
//  cfg      | in  | cfg_valid_i/cfg_ready_o   | cfg_data_i[6:0] max_length
//
//  Each received byte is taken in one cycle while the parser walks the frame.
//  A good frame is sent as n stored bytes (n = length, 1 for length zero),
//  each by a registered store read, then an output register load that waits
//  while that register is full and not being taken. No input is taken during
//  that emission, nor while its final item waits in the output register and
//  is not being taken. Error items are loaded on the byte that caused them;
//  outside emission, input stalls only while the output register is full and
//  not being taken. Reset puts the parser on head search and max_length at
//  64; the byte store is not cleared (only written entries are ever read).

module packet_frame_receiver_unit #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [14:8] frame_length, [15] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i      // max_length
);

  prf_pkg::prf_cmd_t  cmd;
  prf_pkg::prf_stat_t stat;
  logic [7:0]                     out_byte;
  logic [prf_pkg::LEN_W-1:0]      out_len;

  // config is to be written only while idle, a rule the user must keep; cfg_ready_o is tied high, so it is always taken
  assign cfg_ready_o = 1'b1;

  prf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  prf_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .out_status_o (m_axis_tuser),
    .out_len_o    (out_len),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_len, out_byte};

endmodule

>>> dv/prf_frame_checker.sv
// Scoreboard for the packet frame receiver: tracks the byte stream into the block,
// predicts the frame and status items it should send, and checks the output channel.
// Depends on prf_pkg.
`timescale 1ns / 1ps

module prf_frame_checker
  import prf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_data_i,
  input  logic [2:0]  out_user_i,
  input  logic        out_last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [6:0]  cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  typedef struct {
    logic [7:0]       data;
    status_e          stat;
    logic [LEN_W-1:0] flen;
    logic             last;
  } frame_item_t;

  frame_item_t      expected_q[$];
  logic [LEN_W-1:0] max_len;
  state_e           pstate;
  logic [7:0]       frame_mem [MAX_PAYLOAD];
  logic [LEN_W-1:0] rx_count;
  logic [LEN_W-1:0] decl_len;
  logic [7:0]       run_sum;
  int               mismatches;

  // rotate right by one, then add, mod 256
  function automatic logic [7:0] sum_step(logic [7:0] acc, logic [7:0] b);
    logic [7:0] rotated;
    rotated = (acc >> 1) | (acc << 7);
    return rotated + b;
  endfunction

  task automatic report_error(status_e code, logic [LEN_W-1:0] len);
    expected_q.push_back('{data: 8'h00, stat: code, flen: len, last: 1'b1});
    pstate = ST_HEAD;
  endtask

  task automatic keep_byte(logic [7:0] b);
    if (rx_count < MAX_PAYLOAD) frame_mem[rx_count] = b;
    rx_count = rx_count + 1'b1;
  endtask

  task automatic parse_byte(logic [7:0] b);
    logic [7:0] want;
    int         n;
    int         k;
    case (pstate)
      ST_HEAD: begin
        if (b == HEAD_BYTE) begin
          rx_count = '0;
          run_sum  = '0;
          decl_len = '0;
          pstate   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (b <= max_len && b <= MAX_PAYLOAD) begin
          decl_len = b[LEN_W-1:0];
          pstate   = ST_ID;
        end else begin
          report_error(STAT_BAD_LEN, b[LEN_W-1:0]);
        end
      end
      ST_ID: begin
        keep_byte(b);
        run_sum = sum_step(8'h00, b);
        pstate  = (decl_len > 1) ? ST_PAY : ST_TAIL;
      end
      ST_PAY: begin
        keep_byte(b);
        run_sum = sum_step(run_sum, b);
        if (rx_count >= decl_len) pstate = ST_TAIL;
      end
      ST_TAIL: begin
        if (b == TAIL_BYTE) pstate = ST_CSUM;
        else report_error(STAT_BAD_TAIL, decl_len);
      end
      ST_CSUM: begin
        want = (decl_len == 0) ? 8'h00 : run_sum;
        if (b == want) pstate = ST_END1;
        else report_error(STAT_BAD_CSUM, decl_len);
      end
      ST_END1: begin
        if (b == END1_BYTE) pstate = ST_END2;
        else report_error(STAT_BAD_END1, decl_len);
      end
      default: begin
        if (b != END2_BYTE) begin
          report_error(STAT_BAD_END2, decl_len);
        end else begin
          pstate = ST_HEAD;
          // zero length still sends the ID as one item
          n = (decl_len == 0) ? 1 : int'(decl_len);
          if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
          for (k = 0; k < n; k++)
            expected_q.push_back('{data: frame_mem[k], stat: STAT_GOOD, flen: decl_len,
                                   last: (k == n - 1)});
        end
      end
    endcase
  endtask

  task automatic check_item();
    frame_item_t exp_item;
    if (expected_q.size() == 0) begin
      $error("unexpected item: out_byte %0h status %0d frame_length %0d last %0b",
             out_data_i[7:0], out_user_i, out_data_i[14:8], out_last_i);
      mismatches++;
    end else begin
      exp_item = expected_q.pop_front();
      if (out_data_i[7:0] !== exp_item.data) begin
        $error("out_byte: expected %0h, got %0h", exp_item.data, out_data_i[7:0]);
        mismatches++;
      end
      if (out_user_i !== exp_item.stat) begin
        $error("status: expected %0d, got %0d", exp_item.stat, out_user_i);
        mismatches++;
      end
      if (out_data_i[14:8] !== exp_item.flen) begin
        $error("frame_length: expected %0d, got %0d", exp_item.flen, out_data_i[14:8]);
        mismatches++;
      end
      if (out_last_i !== exp_item.last) begin
        $error("last: expected %0b, got %0b", exp_item.last, out_last_i);
        mismatches++;
      end
      if (out_data_i[15] !== 1'b0) begin
        $error("tdata pad: expected 0, got %0b", out_data_i[15]);
        mismatches++;
      end
    end
  endtask

  // inputs are sampled at the edge before the driver's updates land
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      max_len    = MAX_LENGTH_RST;
      pstate     = ST_HEAD;
      rx_count   = '0;
      decl_len   = '0;
      run_sum    = '0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) max_len = cfg_data_i;
      if (out_valid_i && out_ready_i) check_item();
      if (in_valid_i && in_ready_i) parse_byte(in_data_i);
    end
    pending_o <= expected_q.size();
    errors_o  <= mismatches;
  end

endmodule

>>> dv/packet_frame_receiver_unit_tb.sv
// Testbench top for packet_frame_receiver_unit: drives byte streams of good,
// broken and noisy frames across several max_length settings, random stalls both sides.
// Depends on prf_pkg, prf_frame_checker and the block under test.
`timescale 1ns / 1ps

module packet_frame_receiver_unit_tb;
  import prf_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;   // long output hold-off, block backs up
  localparam int PHASE_BYTES = 55;
  localparam int SETTLE      = 30;    // idle cycles after the last result

  typedef enum int {
    FLAW_NONE,
    FLAW_LEN,
    FLAW_TAIL,
    FLAW_CSUM,
    FLAW_END1,
    FLAW_END2,
    FLAW_NOISE
  } flaw_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;       // [7:0] data_byte

  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;               // [7:0] out_byte, [14:8] frame_length, [15] zero
  logic [2:0]  m_user;               // [2:0] status
  logic        m_last;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = 7'd0;      // max_length

  int          pending;
  int          fails;
  int          cycle_cnt = 0;

  logic [7:0]  stream_q[$];          // bytes waiting to be sent
  logic [6:0]  cur_limit;            // max_length as last written
  logic        hold_req = 1'b0;
  logic        src_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  packet_frame_receiver_unit #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  prf_frame_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) frame_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_valid),
    .in_ready_i  (s_ready),
    .in_data_i   (s_data),
    .out_valid_i (m_valid),
    .out_ready_i (m_ready),
    .out_data_i  (m_data),
    .out_user_i  (m_user),
    .out_last_i  (m_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (fails)
  );

  // Queue one frame. Broken frames stop right after the offending byte; the
  // parser is back on head search by then. id >= 0 forces the ID byte.
  task automatic add_frame(int len, flaw_e flaw, int id = -1);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] flip;
    int         k;
    flip = 8'($urandom_range(1, 255));
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    stream_q.push_back(HEAD_BYTE);
    if (flaw == FLAW_LEN) begin
      stream_q.push_back(8'($urandom_range(int'(cur_limit) + 1, 255)));
      return;
    end
    stream_q.push_back(8'(len));
    sum = 8'h00;
    // ID plus payload; length zero still carries the ID
    for (k = 0; k < ((len == 0) ? 1 : len); k++) begin
      b   = (k == 0 && id >= 0) ? 8'(id) : 8'($urandom_range(0, 255));
      sum = {sum[0], sum[7:1]} + b;
      stream_q.push_back(b);
    end
    if (len == 0) sum = 8'h00;
    if (flaw == FLAW_TAIL) begin
      stream_q.push_back(TAIL_BYTE ^ flip);
      return;
    end
    stream_q.push_back(TAIL_BYTE);
    if (flaw == FLAW_CSUM) begin
      stream_q.push_back(sum ^ flip);
      return;
    end
    stream_q.push_back(sum);
    stream_q.push_back((flaw == FLAW_END1) ? (END1_BYTE ^ flip) : END1_BYTE);
    if (flaw == FLAW_END1) return;
    stream_q.push_back((flaw == FLAW_END2) ? (END2_BYTE ^ flip) : END2_BYTE);
  endtask

  // Sender: random gap per item, with stretches of back-to-back items.
  task automatic send_stream();
    int gap;
    while (stream_q.size() > 0) begin
      if ($urandom_range(0, 24) == 0) src_burst = !src_burst;
      gap = src_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_valid <= 1'b1;
      s_data  <= stream_q.pop_front();
      do @(posedge clk); while (!s_ready);
    end
  endtask

  // Pause the sender until every predicted item is out, then let it settle.
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = value;
  endtask

  // Mostly well-formed frames with random content; short lengths dominate,
  // one in ten uses the full limit.
  task automatic random_phase(int target);
    int    len;
    int    cap;
    int    r;
    flaw_e flaw;
    while (stream_q.size() < target) begin
      cap = (cur_limit < 10) ? int'(cur_limit) : 10;
      len = ($urandom_range(0, 9) == 0) ? int'(cur_limit) : $urandom_range(0, cap);
      r   = $urandom_range(0, 99);
      if (r < 65)      flaw = FLAW_NONE;
      else if (r < 70) flaw = FLAW_LEN;
      else if (r < 76) flaw = FLAW_TAIL;
      else if (r < 84) flaw = FLAW_CSUM;
      else if (r < 90) flaw = FLAW_END1;
      else if (r < 96) flaw = FLAW_END2;
      else             flaw = FLAW_NOISE;
      add_frame(len, flaw);
    end
    send_stream();
  endtask

  // Receiver: random stall per item; on request one long hold-off.
  initial begin : sink
    int   gap;
    logic burst;
    burst = 1'b0;
    wait (rst_n == 1'b1);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 24) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [6:0] limits [5];
    logic       held;
    held = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_limit = MAX_LENGTH_RST;

    // Directed: ignored bytes before a head, zero length with an all-ones ID,
    // length one whose ID is the head value, an all-ones length byte and a
    // length one above the store size, both rejected.
    stream_q = '{8'h00, 8'hFF, END2_BYTE};
    add_frame(0, FLAW_NONE, 8'hFF);
    add_frame(1, FLAW_NONE, HEAD_BYTE);
    stream_q.push_back(HEAD_BYTE);
    stream_q.push_back(8'hFF);
    stream_q.push_back(HEAD_BYTE);
    stream_q.push_back(8'(MAX_PAYLOAD + 1));
    send_stream();
    drain();

    // Random phases over several limits, both extremes included.
    limits = '{7'd0, MAX_LENGTH_RST, 7'd7, 7'd1, 7'($urandom_range(2, 63))};
    foreach (limits[i]) begin
      write_limit(limits[i]);
      if (limits[i] == MAX_LENGTH_RST && !held) begin
        // full-size frames while the receiver holds off
        hold_req = 1'b1;
        held     = 1'b1;
        add_frame(int'(MAX_LENGTH_RST), FLAW_NONE);
        add_frame(int'(MAX_LENGTH_RST), FLAW_NONE);
      end
      random_phase(PHASE_BYTES);
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/prf_pkg.sv
design/prf_ram.sv
design/prf_ctrl.sv
design/prf_dpath.sv
design/packet_frame_receiver_unit.sv
dv/prf_frame_checker.sv
dv/packet_frame_receiver_unit_tb.sv
